// ===== hdl/uarb_pkg.sv =====
package uarb_pkg;

    localparam int RX_DEPTH = 128;
    localparam int TX_DEPTH = 16;
    localparam int RX_AW = $clog2(RX_DEPTH);
    localparam int TX_AW = $clog2(TX_DEPTH);
    localparam int BYTE_W = 8;
    localparam int KIND_W = 3;
    localparam int RX_COUNT_W = 7;

    typedef enum logic [KIND_W-1:0] {
        KIND_RX_BYTE  = 3'd0,
        KIND_RX_POP   = 3'd1,
        KIND_RX_FLUSH = 3'd2,
        KIND_TX_PUSH  = 3'd3,
        KIND_TX_READY = 3'd4,
        KIND_TX_DONE  = 3'd5
    } kind_t;

    // per-beat decision from the pointer control, plus ring access requests
    typedef struct packed {
        logic                  pop_valid;
        logic                  dropped;
        logic                  ready;
        logic                  accepted;
        logic                  send_valid;
        logic                  line_active;
        logic [RX_COUNT_W-1:0] rx_count;
    } step_t;

    typedef struct packed {
        logic             rx_we;
        logic [RX_AW-1:0] rx_waddr;
        logic             rx_re;
        logic [RX_AW-1:0] rx_raddr;
        logic             tx_we;
        logic [TX_AW-1:0] tx_waddr;
        logic             tx_re;
        logic [TX_AW-1:0] tx_raddr;
    } mem_req_t;

endpackage

// ===== hdl/uart_rx_tx_ring_buffers.sv =====
// pipeline: a beat passes the middle stage (s1) and then the output register before
// its result is valid; a stalled result holds the input once the middle stage is
// full
// throughput: one beat per cycle when not stalled; each beat does at most one read
// or one write on one ring memory, read data comes back the cycle after the access
// reset: pointers cleared and tx phase idle at once; ring contents are not cleared
module uart_rx_tx_ring_buffers
    import uarb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  logic [KIND_W-1:0]     kind,
    input  logic [BYTE_W-1:0]     byte_in,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output logic                  pop_valid,
    output logic [BYTE_W-1:0]     pop_byte,
    output logic [RX_COUNT_W-1:0] rx_count,
    output logic                  rx_dropped_oldest,
    output logic                  rx_arrived,
    output logic                  push_accepted,
    output logic                  send_valid,
    output logic [BYTE_W-1:0]     send_byte,
    output logic                  tx_line_active
);

    logic        accept, advance;
    step_t       step, s1_step_reg;
    mem_req_t    mem_req;
    logic        s1_valid_reg, out_valid_reg;
    logic [BYTE_W-1:0] rx_rdata, tx_rdata;
    step_t             out_step_reg;
    logic [BYTE_W-1:0] out_pop_byte_reg, out_send_byte_reg;

    assign advance   = !out_valid_reg || !rsp_stall;
    assign req_stall = s1_valid_reg && !advance;
    assign accept    = req_valid && !req_stall;

    uarb_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (accept),
        .kind    (kind),
        .step    (step),
        .mem_req (mem_req)
    );

    uarb_ram #(
        .DEPTH (RX_DEPTH),
        .WIDTH (BYTE_W)
    ) u_rx_ram (
        .clk   (clk),
        .we    (mem_req.rx_we),
        .waddr (mem_req.rx_waddr),
        .wdata (byte_in),
        .re    (mem_req.rx_re),
        .raddr (mem_req.rx_raddr),
        .rdata (rx_rdata)
    );

    uarb_ram #(
        .DEPTH (TX_DEPTH),
        .WIDTH (BYTE_W)
    ) u_tx_ram (
        .clk   (clk),
        .we    (mem_req.tx_we),
        .waddr (mem_req.tx_waddr),
        .wdata (byte_in),
        .re    (mem_req.tx_re),
        .raddr (mem_req.tx_raddr),
        .rdata (tx_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= accept || (s1_valid_reg && !advance);
            out_valid_reg <= s1_valid_reg || (out_valid_reg && rsp_stall);
        end
    end

    // ram read data holds while the beat waits, since no new beat is taken
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_step_reg <= step;
        end
        if (s1_valid_reg && advance)
        begin
            out_step_reg      <= s1_step_reg;
            out_pop_byte_reg  <= s1_step_reg.pop_valid ? rx_rdata : '0;
            out_send_byte_reg <= s1_step_reg.send_valid ? tx_rdata : '0;
        end
    end

    assign rsp_valid         = out_valid_reg;
    assign pop_valid         = out_step_reg.pop_valid;
    assign pop_byte          = out_pop_byte_reg;
    assign rx_count          = out_step_reg.rx_count;
    assign rx_dropped_oldest = out_step_reg.dropped;
    assign rx_arrived        = out_step_reg.ready;
    assign push_accepted     = out_step_reg.accepted;
    assign send_valid        = out_step_reg.send_valid;
    assign send_byte         = out_send_byte_reg;
    assign tx_line_active    = out_step_reg.line_active;

endmodule

// ===== hdl/uarb_ram.sv =====
module uarb_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/uarb_ctrl.sv =====
module uarb_ctrl
    import uarb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              go,
    input  logic [KIND_W-1:0] kind,
    output step_t             step,
    output mem_req_t          mem_req
);

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_PUMP = 2'd1,
        PH_WAIT = 2'd2
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic [RX_AW-1:0] rx_wp_reg, rx_wp_next, rx_rp_reg, rx_rp_next;
    logic [TX_AW-1:0] tx_wp_reg, tx_wp_next, tx_rp_reg, tx_rp_next;
    logic [RX_AW-1:0] rx_wp_inc, rx_rp_inc, rx_fill;
    logic [TX_AW-1:0] tx_wp_inc, tx_rp_inc;

    assign rx_wp_inc = (rx_wp_reg == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_wp_reg + 1'b1;
    assign rx_rp_inc = (rx_rp_reg == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_rp_reg + 1'b1;
    assign tx_wp_inc = (tx_wp_reg == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_wp_reg + 1'b1;
    assign tx_rp_inc = (tx_rp_reg == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_rp_reg + 1'b1;

    always_comb
    begin
        phase_next = phase_reg;
        rx_wp_next = rx_wp_reg;
        rx_rp_next = rx_rp_reg;
        tx_wp_next = tx_wp_reg;
        tx_rp_next = tx_rp_reg;
        step       = '0;
        mem_req    = '0;
        mem_req.rx_waddr = rx_wp_reg;
        mem_req.rx_raddr = rx_rp_reg;
        mem_req.tx_waddr = tx_wp_reg;
        mem_req.tx_raddr = tx_rp_reg;
        if (go)
        begin
            case (kind)
                KIND_RX_BYTE:
                begin
                    // full ring: drop the oldest byte to make room
                    if (rx_wp_inc == rx_rp_reg)
                    begin
                        rx_rp_next   = rx_rp_inc;
                        step.dropped = 1'b1;
                    end
                    mem_req.rx_we = 1'b1;
                    rx_wp_next    = rx_wp_inc;
                    step.ready    = 1'b1;
                end
                KIND_RX_POP:
                begin
                    if (rx_wp_reg != rx_rp_reg)
                    begin
                        step.pop_valid = 1'b1;
                        mem_req.rx_re  = 1'b1;
                        rx_rp_next     = rx_rp_inc;
                    end
                end
                KIND_RX_FLUSH:
                begin
                    rx_rp_next = rx_wp_reg;
                end
                KIND_TX_PUSH:
                begin
                    if (tx_wp_inc != tx_rp_reg)
                    begin
                        mem_req.tx_we = 1'b1;
                        tx_wp_next    = tx_wp_inc;
                        step.accepted = 1'b1;
                        phase_next    = PH_PUMP;
                    end
                end
                KIND_TX_READY:
                begin
                    if (phase_reg == PH_PUMP)
                    begin
                        if (tx_wp_reg == tx_rp_reg)
                        begin
                            phase_next = PH_WAIT;
                        end
                        else
                        begin
                            step.send_valid = 1'b1;
                            mem_req.tx_re   = 1'b1;
                            tx_rp_next      = tx_rp_inc;
                        end
                    end
                end
                KIND_TX_DONE:
                begin
                    if (phase_reg == PH_WAIT)
                    begin
                        phase_next = (tx_wp_reg != tx_rp_reg) ? PH_PUMP : PH_IDLE;
                    end
                end
                default:
                begin
                end
            endcase
        end
        rx_fill = rx_wp_next - rx_rp_next;
        if (rx_wp_next < rx_rp_next)
        begin
            rx_fill = RX_AW'(RX_DEPTH) + rx_wp_next - rx_rp_next;
        end
        step.rx_count    = RX_COUNT_W'(rx_fill);
        step.line_active = (phase_next == PH_PUMP) || (phase_next == PH_WAIT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            rx_wp_reg <= '0;
            rx_rp_reg <= '0;
            tx_wp_reg <= '0;
            tx_rp_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            rx_wp_reg <= rx_wp_next;
            rx_rp_reg <= rx_rp_next;
            tx_wp_reg <= tx_wp_next;
            tx_rp_reg <= tx_rp_next;
        end
    end

endmodule

// ===== bench/tb_uart_rx_tx_ring_buffers.sv =====
module tb_uart_rx_tx_ring_buffers;
    import uarb_pkg::*;

    localparam int WATCHDOG_LIMIT = 500;
    localparam int DRAIN_CYCLES = 6;

    typedef enum logic [1:0] {
        TXS_IDLE = 2'd0,
        TXS_PUMP = 2'd1,
        TXS_WAIT = 2'd2
    } tx_state_t;

    typedef struct packed {
        logic                  pop_valid;
        logic [BYTE_W-1:0]     pop_byte;
        logic [RX_COUNT_W-1:0] rx_count;
        logic                  dropped;
        logic                  arrived;
        logic                  accepted;
        logic                  send_valid;
        logic [BYTE_W-1:0]     send_byte;
        logic                  line_active;
    } ring_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  req_valid = 1'b0;
    logic                  req_stall;
    logic [KIND_W-1:0]     kind = '0;
    logic [BYTE_W-1:0]     byte_in = '0;
    logic                  rsp_valid;
    logic                  rsp_stall = 1'b0;
    logic                  pop_valid;
    logic [BYTE_W-1:0]     pop_byte;
    logic [RX_COUNT_W-1:0] rx_count;
    logic                  rx_dropped_oldest;
    logic                  rx_arrived;
    logic                  push_accepted;
    logic                  send_valid;
    logic [BYTE_W-1:0]     send_byte;
    logic                  tx_line_active;

    // shadow copy of both rings
    logic [BYTE_W-1:0] rx_mem [RX_DEPTH];
    logic [BYTE_W-1:0] tx_mem [TX_DEPTH];
    logic [RX_AW-1:0]  rx_wr = '0;
    logic [RX_AW-1:0]  rx_rd = '0;
    logic [TX_AW-1:0]  tx_wr = '0;
    logic [TX_AW-1:0]  tx_rd = '0;
    tx_state_t         tx_state = TXS_IDLE;

    ring_result_t pending_results [$];

    bit idle_on = 1'b1;
    int mismatches = 0;
    int beats_sent = 0;
    int results_checked = 0;
    int drops_seen = 0;
    int refusals_seen = 0;
    int bytes_popped = 0;
    int bytes_sent = 0;
    int kind_hits [8];

    uart_rx_tx_ring_buffers dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .req_valid         (req_valid),
        .req_stall         (req_stall),
        .kind              (kind),
        .byte_in           (byte_in),
        .rsp_valid         (rsp_valid),
        .rsp_stall         (rsp_stall),
        .pop_valid         (pop_valid),
        .pop_byte          (pop_byte),
        .rx_count          (rx_count),
        .rx_dropped_oldest (rx_dropped_oldest),
        .rx_arrived        (rx_arrived),
        .push_accepted     (push_accepted),
        .send_valid        (send_valid),
        .send_byte         (send_byte),
        .tx_line_active    (tx_line_active)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic logic [RX_AW-1:0] rx_bump(input logic [RX_AW-1:0] p);
        return (int'(p) == RX_DEPTH - 1) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [TX_AW-1:0] tx_bump(input logic [TX_AW-1:0] p);
        return (int'(p) == TX_DEPTH - 1) ? '0 : p + 1'b1;
    endfunction

    // advance the shadow rings by one beat and return what the block should report
    function automatic ring_result_t ring_step(input logic [KIND_W-1:0] k,
                                               input logic [BYTE_W-1:0] b);
        ring_result_t r;
        logic [RX_AW-1:0] rx_nx;
        logic [TX_AW-1:0] tx_nx;
        r = '0;
        case (k)
            KIND_RX_BYTE:
            begin
                rx_nx = rx_bump(rx_wr);
                if (rx_nx == rx_rd)
                begin
                    rx_rd = rx_bump(rx_rd);
                    r.dropped = 1'b1;
                end
                rx_mem[rx_wr] = b;
                rx_wr = rx_nx;
                r.arrived = 1'b1;
            end
            KIND_RX_POP:
            begin
                if (rx_wr != rx_rd)
                begin
                    r.pop_valid = 1'b1;
                    r.pop_byte = rx_mem[rx_rd];
                    rx_rd = rx_bump(rx_rd);
                end
            end
            KIND_RX_FLUSH:
                rx_rd = rx_wr;
            KIND_TX_PUSH:
            begin
                tx_nx = tx_bump(tx_wr);
                if (tx_nx != tx_rd)
                begin
                    tx_mem[tx_wr] = b;
                    tx_wr = tx_nx;
                    r.accepted = 1'b1;
                    tx_state = TXS_PUMP;
                end
            end
            KIND_TX_READY:
            begin
                if (tx_state == TXS_PUMP)
                begin
                    if (tx_wr == tx_rd)
                        tx_state = TXS_WAIT;
                    else
                    begin
                        r.send_valid = 1'b1;
                        r.send_byte = tx_mem[tx_rd];
                        tx_rd = tx_bump(tx_rd);
                    end
                end
            end
            KIND_TX_DONE:
            begin
                if (tx_state == TXS_WAIT)
                    tx_state = (tx_wr != tx_rd) ? TXS_PUMP : TXS_IDLE;
            end
            default:
            begin
            end
        endcase
        r.rx_count = RX_COUNT_W'((int'(rx_wr) - int'(rx_rd) + RX_DEPTH) % RX_DEPTH);
        r.line_active = (tx_state == TXS_PUMP) || (tx_state == TXS_WAIT);
        return r;
    endfunction

    task automatic send_beat(input logic [KIND_W-1:0] k, input logic [BYTE_W-1:0] b);
        ring_result_t r;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        req_valid <= 1'b1;
        kind <= k;
        byte_in <= b;
        do
            @(posedge clk);
        while (req_stall);
        r = ring_step(k, b);
        pending_results.push_back(r);
        beats_sent++;
        kind_hits[k]++;
        if (r.dropped)
            drops_seen++;
        if (k == KIND_TX_PUSH && !r.accepted)
            refusals_seen++;
        if (r.pop_valid)
            bytes_popped++;
        if (r.send_valid)
            bytes_sent++;
    endtask

    function automatic logic [BYTE_W-1:0] rand_byte();
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    // bias 0 balanced, 1 arrivals heavy, 2 pops heavy, 3 tx heavy
    function automatic logic [KIND_W-1:0] pick_kind(input int bias);
        int roll;
        roll = $urandom_range(0, 99);
        case (bias)
            1: roll = (roll < 50) ? 0 : roll;
            2: roll = (roll < 45) ? 30 : roll;
            3: roll = (roll < 40) ? 60 : roll;
            default:
            begin
            end
        endcase
        if (roll < 25) return KIND_RX_BYTE;
        if (roll < 45) return KIND_RX_POP;
        if (roll < 48) return KIND_RX_FLUSH;
        if (roll < 68) return KIND_TX_PUSH;
        if (roll < 86) return KIND_TX_READY;
        if (roll < 96) return KIND_TX_DONE;
        return KIND_W'($urandom_range(6, 7));
    endfunction

    task automatic test_empty_and_ignored();
        send_beat(KIND_RX_POP, 8'h00);
        send_beat(KIND_TX_READY, 8'hFF);
        send_beat(KIND_TX_DONE, 8'h00);
    endtask

    task automatic test_rx_basic();
        send_beat(KIND_RX_BYTE, 8'h00);
        send_beat(KIND_RX_BYTE, 8'hFF);
        send_beat(KIND_RX_POP, 8'hFF);
        send_beat(KIND_RX_POP, 8'h00);
        send_beat(KIND_RX_BYTE, 8'hA5);
        send_beat(KIND_RX_BYTE, 8'h5A);
        send_beat(KIND_RX_FLUSH, 8'hFF);
        send_beat(KIND_RX_POP, 8'h00);
    endtask

    task automatic test_tx_handshake();
        send_beat(KIND_TX_PUSH, 8'hFF);
        send_beat(KIND_TX_PUSH, 8'h00);
        send_beat(KIND_TX_READY, 8'h00);
        // complete while pumping is not armed
        send_beat(KIND_TX_DONE, 8'h00);
        send_beat(KIND_TX_READY, 8'h00);
        send_beat(KIND_TX_READY, 8'h00);
        // ready while waiting for complete is not armed
        send_beat(KIND_TX_READY, 8'h00);
        send_beat(KIND_TX_PUSH, 8'h3C);
        send_beat(KIND_TX_DONE, 8'h00);
        send_beat(KIND_TX_READY, 8'h00);
        send_beat(KIND_TX_READY, 8'h00);
        send_beat(KIND_TX_DONE, 8'h00);
    endtask

    task automatic test_unknown_kinds();
        send_beat(KIND_W'(6), 8'hC3);
        send_beat(KIND_W'(7), 8'h3C);
    endtask

    task automatic test_rx_overflow();
        repeat (RX_DEPTH - 1) send_beat(KIND_RX_BYTE, rand_byte());
        repeat (RX_DEPTH / 8) send_beat(KIND_RX_BYTE, rand_byte());
        repeat (RX_DEPTH + 1) send_beat(KIND_RX_POP, rand_byte());
    endtask

    task automatic test_tx_full();
        repeat (TX_DEPTH - 1) send_beat(KIND_TX_PUSH, rand_byte());
        repeat (3) send_beat(KIND_TX_PUSH, rand_byte());
        repeat (TX_DEPTH) send_beat(KIND_TX_READY, rand_byte());
        send_beat(KIND_TX_DONE, rand_byte());
    endtask

    // mostly well-formed frames on either side, with noise runs in between
    task automatic test_random_mix(input int target);
        int n;
        int bias;
        int choice;
        while (beats_sent < target)
        begin
            choice = $urandom_range(0, 9);
            n = $urandom_range(1, 8);
            if (choice < 4)
            begin
                repeat (n) send_beat(KIND_TX_PUSH, rand_byte());
                repeat (n + $urandom_range(0, 2)) send_beat(KIND_TX_READY, rand_byte());
                send_beat(KIND_TX_DONE, rand_byte());
            end
            else if (choice < 7)
            begin
                repeat (n) send_beat(KIND_RX_BYTE, rand_byte());
                repeat ($urandom_range(0, n + 1)) send_beat(KIND_RX_POP, rand_byte());
            end
            else
            begin
                bias = $urandom_range(0, 3);
                repeat (10) send_beat(pick_kind(bias), rand_byte());
            end
        end
    endtask

    task automatic test_back_to_back(input int count);
        idle_on = 1'b0;
        repeat (count) send_beat(pick_kind($urandom_range(0, 3)), rand_byte());
    endtask

    // receiver stalls in short random bursts
    int stall_left = 0;
    always @(posedge clk)
    begin
        if (!rst_n || !idle_on)
        begin
            stall_left = 0;
            rsp_stall <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            rsp_stall <= 1'b1;
        end
        else if ($urandom_range(0, 6) == 0)
        begin
            stall_left = $urandom_range(0, 3);
            rsp_stall <= 1'b1;
        end
        else
            rsp_stall <= 1'b0;
    end

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin
        ring_result_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                $display("%0t: result with nothing expected, expected none, actual pop %0h",
                         $time, pop_byte);
            end
            else
            begin
                want = pending_results.pop_front();
                results_checked++;
                check_field("pop_valid", want.pop_valid, pop_valid);
                check_field("pop_byte", want.pop_byte, pop_byte);
                check_field("rx_count", want.rx_count, rx_count);
                check_field("rx_dropped_oldest", want.dropped, rx_dropped_oldest);
                check_field("rx_arrived", want.arrived, rx_arrived);
                check_field("push_accepted", want.accepted, push_accepted);
                check_field("send_valid", want.send_valid, send_valid);
                check_field("send_byte", want.send_byte, send_byte);
                check_field("tx_line_active", want.line_active, tx_line_active);
            end
        end
    end

    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: watchdog expired with %0d results outstanding",
                 $time, pending_results.size());
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_and_ignored();
        test_rx_basic();
        test_tx_handshake();
        test_unknown_kinds();
        test_rx_overflow();
        test_tx_full();
        test_random_mix(900);
        test_back_to_back(150);
        req_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("tb: %0d beats, %0d results checked, %0d mismatching fields",
                 beats_sent, results_checked, mismatches);
        $display("tb: %0d rx drops, %0d refused pushes, %0d popped, %0d sent, kinds 6/7 %0d",
                 drops_seen, refusals_seen, bytes_popped, bytes_sent,
                 kind_hits[6] + kind_hits[7]);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
